FILE: design/tsm_pkg.sv
// Shared constants and the quarter-wave sine entry generator for the tremolo LFO.
package tsm_pkg;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [2:0] REG_INC    = 3'd0;
  localparam logic [2:0] REG_DEPTH  = 3'd1;
  localparam logic [2:0] REG_SHAPE  = 3'd2;
  localparam logic [2:0] REG_OFFSET = 3'd3;
  localparam logic [2:0] REG_STEREO = 3'd4;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  // 1.0 in Q1.15
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // sin(x) for x in Q30, Taylor series to x^13/13!, each term truncated,
  // rounded half-up to Q15 and clamped to [0, 1.0]. Elaboration only.
  function automatic logic [15:0] sine_q15(input logic [63:0] x);
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32768) begin
      q = 64'sd32768;
    end
    return q[15:0];
  endfunction

endpackage

FILE: design/tsm_in_if.sv
// Input frame channel: one stereo frame per beat plus the phase restart flag.
interface tsm_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          restart_phase;

  modport source (output valid, left_sample, right_sample, restart_phase, input ready);
  modport sink   (input valid, left_sample, right_sample, restart_phase, output ready);
endinterface

FILE: design/tsm_out_if.sv
// Output frame channel: one modulated stereo frame per beat.
interface tsm_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

FILE: design/tremolo_shape_morph_lfo_unit.sv
// Stereo tremolo with a sine-to-square morphing LFO, bit-serial datapath.
//
// Usage:
//   in_i  : one stereo frame per beat (valid/ready). restart_phase clears the
//           LFO phase before the frame is processed.
//   out_o : one modulated stereo frame per input beat (valid/ready).
//   APB   : five registers at byte addresses 0,4,8,12,16 (increment, depth,
//           shape, offset, stereo). Write them only while the block is idle.
// Timing:
//   All four multiplies of a channel (table index, shape morph, depth,
//   sample gain) run through one shift-and-add multiplier, 1 multiplier
//   bit per cycle. A frame is accepted only while the sequencer is idle,
//   so a new frame waits until the last result is in the output register.
//   Stereo: both channels run in turn before the frame's result is written.
// Stalls:
//   The result sits in an output register; the next frame is accepted while
//   it waits. If the register is still full when the next result is ready,
//   the datapath holds until the receiver takes the pending beat.
// Reset: control and config regs and LFO phase clear; no output pending.
module tremolo_shape_morph_lfo_unit #(
  parameter int SAMPLE_BITS          = 24,
  parameter int QUARTER_SINE_ENTRIES = 256,
  parameter int PHASE_BITS           = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsm_in_if.sink      in_i,
  tsm_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N   = QUARTER_SINE_ENTRIES;
  localparam int NB  = $clog2(N + 1);
  localparam int PB  = PHASE_BITS;
  localparam int SB  = SAMPLE_BITS;
  localparam int MPW = 16;
  localparam int MW0 = (PB - 1 > SB) ? PB - 1 : SB;
  localparam int MW  = (MW0 > 19) ? MW0 : 19;
  localparam int AW  = MW + MPW;

  localparam logic [MPW-1:0]       N_MUL = MPW'(N);
  localparam logic [NB-1:0]        N_IDX = NB'(N);
  localparam logic signed [AW-1:0] RND15 = AW'(16384);
  localparam logic signed [AW-1:0] RND16 = AW'(32768);

  // Sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_IDX   = 4'd2;
  localparam logic [3:0] S_LOOK  = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_SHP   = 4'd5;
  localparam logic [3:0] S_LFO   = 4'd6;
  localparam logic [3:0] S_DEP   = 4'd7;
  localparam logic [3:0] S_GAIN  = 4'd8;
  localparam logic [3:0] S_SMP   = 4'd9;
  localparam logic [3:0] S_RES   = 4'd10;

  // Configuration registers
  logic [31:0] inc_q, off_q;
  logic [15:0] depth_q, shape_q;
  logic        stereo_q;
  logic        cfg_we;

  // Control state
  logic [3:0]    state_q, state_d;
  logic          ch_q, ch_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic [PB-1:0] phase_q, phase_d;

  // Datapath registers
  logic [PB-1:0]          cur_q, cur_d;
  logic signed [SB-1:0]   lin_q, lin_d, rin_q, rin_d;
  logic signed [AW-1:0]   acc_q, acc_d;
  logic signed [MW-1:0]   mcand_q, mcand_d;
  logic [MPW-1:0]         mplier_q, mplier_d;
  logic [NB-1:0]          idx_q, idx_d;
  logic signed [16:0]     sine_q, sine_d;
  logic signed [SB-1:0]   hold_q, hold_d;
  logic signed [SB-1:0]   lout_q, lout_d, rout_q, rout_d;

  // Derived values
  logic [PB-1:0]        inc_s, off_s, p_cur;
  logic [1:0]           quad;
  logic [NB-1:0]        idx_raw;
  logic [15:0]          sine_rom [N+1];
  logic signed [16:0]   sine_rd;
  logic signed [17:0]   square, diff;
  logic signed [AW-1:0] step, rnd15, rnd16;
  logic signed [18:0]   lfo, dm;
  logic [16:0]          gain;
  logic [15:0]          shp_sat, dep_sat;

  // Quarter-wave sine table, built at elaboration
  for (genvar k = 0; k <= N; k++) begin : g_tab
    localparam logic [63:0] X =
      (tsm_pkg::HALF_PI_Q30 * 64'(k) + 64'(N / 2)) / QUARTER_SINE_ENTRIES;
    localparam logic [15:0] V = tsm_pkg::sine_q15(X);
    assign sine_rom[k] = V;
  end

  // 32-bit register fractions scaled to the phase width
  if (PHASE_BITS > 32) begin : g_scale_up
    assign inc_s = {inc_q, {(PHASE_BITS - 32){1'b0}}};
    assign off_s = {off_q, {(PHASE_BITS - 32){1'b0}}};
  end else if (PHASE_BITS == 32) begin : g_scale_eq
    assign inc_s = inc_q;
    assign off_s = off_q;
  end else begin : g_scale_dn
    assign inc_s = inc_q[31 -: PHASE_BITS];
    assign off_s = off_q[31 -: PHASE_BITS];
  end

  // APB register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[4:2])
      tsm_pkg::REG_INC:    prdata = inc_q;
      tsm_pkg::REG_DEPTH:  prdata = {16'd0, depth_q};
      tsm_pkg::REG_SHAPE:  prdata = {16'd0, shape_q};
      tsm_pkg::REG_OFFSET: prdata = off_q;
      tsm_pkg::REG_STEREO: prdata = {31'd0, stereo_q};
      default:             prdata = 32'd0;
    endcase
  end

  // Channel phase, quadrant and saturated controls
  assign p_cur   = ch_q ? cur_q + off_s : cur_q;
  assign quad    = p_cur[PB-1 -: 2];
  assign idx_raw = acc_q[PB-2 +: NB];
  assign shp_sat = (shape_q > tsm_pkg::ONE_Q15) ? tsm_pkg::ONE_Q15 : shape_q;
  assign dep_sat = (depth_q > tsm_pkg::ONE_Q15) ? tsm_pkg::ONE_Q15 : depth_q;

  // Shift-and-add step, multiplier MSB first
  assign step  = (acc_q <<< 1) + (mplier_q[MPW-1] ? AW'(mcand_q) : '0);
  assign rnd15 = (acc_q + RND15) >>> 15;
  assign rnd16 = (acc_q + RND16) >>> 16;

  // Signed table read for the current quadrant
  assign sine_rd = quad[1] ? -$signed({1'b0, sine_rom[idx_q]})
                           : $signed({1'b0, sine_rom[idx_q]});

  // Morph and gain arithmetic
  assign square = quad[1] ? -18'sd32768 : 18'sd32768;
  assign diff   = square - 18'(sine_rd);
  assign lfo    = 19'(sine_q) + $signed(rnd15[18:0]);
  assign dm     = 19'sd32768 - lfo;
  assign gain   = 17'd32768 - rnd16[16:0];

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = lout_q;
  assign out_o.right_out = rout_q;

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    cur_d       = cur_q;
    lin_d       = lin_q;
    rin_d       = rin_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    idx_d       = idx_q;
    sine_d      = sine_q;
    hold_d      = hold_q;
    lout_d      = lout_q;
    rout_d      = rout_q;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cur_d   = in_i.restart_phase ? '0 : phase_q;
          phase_d = cur_d + inc_s;
          lin_d   = in_i.left_sample;
          rin_d   = in_i.right_sample;
          ch_d    = 1'b0;
          state_d = S_START;
        end
      end
      S_START: begin
        // f * N gives the table index in its upper bits
        acc_d    = '0;
        mcand_d  = $signed({{(MW - PB + 2){1'b0}}, p_cur[PB-3:0]});
        mplier_d = N_MUL;
        cnt_d    = '1;
        state_d  = S_IDX;
      end
      S_IDX, S_SHP, S_DEP, S_SMP: begin
        acc_d    = step;
        mplier_d = mplier_q << 1;
        cnt_d    = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          unique case (state_q)
            S_IDX:   state_d = S_LOOK;
            S_SHP:   state_d = S_LFO;
            S_DEP:   state_d = S_GAIN;
            default: state_d = S_RES;
          endcase
        end
      end
      S_LOOK: begin
        idx_d   = quad[0] ? N_IDX - idx_raw : idx_raw;
        state_d = S_READ;
      end
      S_READ: begin
        sine_d   = sine_rd;
        acc_d    = '0;
        mcand_d  = MW'(diff);
        mplier_d = shp_sat;
        cnt_d    = '1;
        state_d  = S_SHP;
      end
      S_LFO: begin
        acc_d    = '0;
        mcand_d  = MW'(dm);
        mplier_d = dep_sat;
        cnt_d    = '1;
        state_d  = S_DEP;
      end
      S_GAIN: begin
        acc_d    = '0;
        mcand_d  = ch_q ? MW'(rin_q) : MW'(lin_q);
        mplier_d = gain[15:0];
        cnt_d    = '1;
        state_d  = S_SMP;
      end
      S_RES: begin
        if (!ch_q && stereo_q) begin
          hold_d  = rnd15[SB-1:0];
          ch_d    = 1'b1;
          state_d = S_START;
        end else if (!out_valid_q || out_o.ready) begin
          lout_d      = ch_q ? hold_q : rnd15[SB-1:0];
          rout_d      = ch_q ? rnd15[SB-1:0] : rin_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
      inc_q       <= '0;
      depth_q     <= '0;
      shape_q     <= '0;
      off_q       <= '0;
      stereo_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      if (cfg_we) begin
        unique case (paddr[4:2])
          tsm_pkg::REG_INC:    inc_q    <= pwdata;
          tsm_pkg::REG_DEPTH:  depth_q  <= pwdata[15:0];
          tsm_pkg::REG_SHAPE:  shape_q  <= pwdata[15:0];
          tsm_pkg::REG_OFFSET: off_q    <= pwdata;
          tsm_pkg::REG_STEREO: stereo_q <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    lin_q    <= lin_d;
    rin_q    <= rin_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    idx_q    <= idx_d;
    sine_q   <= sine_d;
    hold_q   <= hold_d;
    lout_q   <= lout_d;
    rout_q   <= rout_d;
  end

endmodule
